FILE: rtl/faa_pkg.sv
package faa_pkg;

  // Operation a classified sample asks of the accumulator store.
  localparam logic [1:0] OP_LOAD = 2'd0;  // first frame of a run: overwrite
  localparam logic [1:0] OP_ADD  = 2'd1;  // later frames: add with wrap
  localparam logic [1:0] OP_EMIT = 2'd2;  // averaged frame: read and shift

  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = 32;
  localparam int FRAME_W     = 16;
  localparam int SHIFT_W     = 5;
  localparam int QUEUE_DEPTH = 4;

  // Register map (byte address bit 2 selects the register).
  localparam logic REG_ACC_MAX   = 1'b0;
  localparam logic REG_ACC_SHIFT = 1'b1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [1:0]          op;
    logic                last;
  } item_t;

endpackage

FILE: rtl/faa_front.sv
module faa_front #(
  parameter int POINTS = 2048,
  parameter int IDX_W  = $clog2(POINTS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [15:0]                  s_tdata,
  input  logic                         s_tlast,
  input  logic [faa_pkg::FRAME_W-1:0]  acc_max,
  input  logic                         busy,
  input  logic                         q_full,
  output logic                         q_push,
  output logic [IDX_W-1:0]             q_idx,
  output faa_pkg::item_t               q_item
);

  logic [IDX_W-1:0]            point_index;
  logic [faa_pkg::FRAME_W-1:0] frames_summed;
  logic                        emitting_frame;
  logic                        frame_open;
  logic                        emit_now;
  logic                        accept;

  assign s_tready = !busy && !q_full;
  assign accept   = s_tvalid && s_tready;

  // A frame's mode is fixed at its first point.
  assign emit_now = frame_open ? emitting_frame : (frames_summed >= acc_max);

  always_comb begin
    q_push         = accept;
    q_idx          = point_index;
    q_item.sample  = s_tdata[faa_pkg::SAMPLE_W-1:0];
    q_item.last    = s_tlast;
    if (emit_now) begin
      q_item.op = faa_pkg::OP_EMIT;
    end else if (frames_summed == '0) begin
      q_item.op = faa_pkg::OP_LOAD;
    end else begin
      q_item.op = faa_pkg::OP_ADD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_index    <= '0;
      frames_summed  <= '0;
      emitting_frame <= 1'b0;
      frame_open     <= 1'b0;
    end else if (accept) begin
      emitting_frame <= emit_now;
      if (s_tlast) begin
        point_index <= '0;
        frame_open  <= 1'b0;
        if (emit_now) begin
          frames_summed <= '0;
        end else begin
          frames_summed <= frames_summed + 1'b1;
        end
      end else begin
        frame_open <= 1'b1;
        if (point_index == IDX_W'(POINTS - 1)) begin
          point_index <= '0;
        end else begin
          point_index <= point_index + 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/faa_queue.sv
module faa_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] head
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/faa_back.sv
module faa_back #(
  parameter int POINTS = 2048,
  parameter int IDX_W  = $clog2(POINTS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [faa_pkg::SHIFT_W-1:0]  acc_shift,
  output logic                         busy,
  input  logic                         q_valid,
  input  logic [IDX_W-1:0]             q_idx,
  input  faa_pkg::item_t               q_item,
  output logic                         q_pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [15:0]                  m_tdata,
  output logic                         m_tlast
);

  logic [faa_pkg::SUM_W-1:0] sums [POINTS];

  logic                      clearing;
  logic [IDX_W-1:0]          clr_addr;

  logic                      b_valid;
  logic [IDX_W-1:0]          b_idx;
  faa_pkg::item_t            b_item;
  logic [faa_pkg::SUM_W-1:0] mem_q;
  logic                      fwd_hit;
  logic [faa_pkg::SUM_W-1:0] fwd_data;

  logic [faa_pkg::SUM_W-1:0] old_sum;
  logic [faa_pkg::SUM_W-1:0] new_sum;
  logic [faa_pkg::SUM_W-1:0] shifted;
  logic                      is_emit;
  logic                      out_ready;
  logic                      b_done;
  logic                      b_ready;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic [faa_pkg::SUM_W-1:0] wr_data;

  assign busy = clearing;

  // The write of the previous operation lands on the edge at which this one
  // is read, so a hit on the same entry takes the written value instead.
  assign old_sum = fwd_hit ? fwd_data : mem_q;
  assign shifted = faa_pkg::SUM_W'($signed(old_sum) >>> acc_shift);
  assign is_emit = (b_item.op == faa_pkg::OP_EMIT);

  always_comb begin
    case (b_item.op)
      faa_pkg::OP_LOAD: new_sum = {{(faa_pkg::SUM_W - faa_pkg::SAMPLE_W){b_item.sample[15]}},
                                   b_item.sample};
      faa_pkg::OP_ADD:  new_sum = old_sum + {{(faa_pkg::SUM_W - faa_pkg::SAMPLE_W)
                                   {b_item.sample[15]}}, b_item.sample};
      default:          new_sum = old_sum;
    endcase
  end

  assign out_ready = !m_tvalid || m_tready;
  assign b_done    = b_valid && (!is_emit || out_ready);
  assign b_ready   = !b_valid || b_done;
  assign q_pop     = q_valid && b_ready && !clearing;

  assign wr_en   = clearing || (b_done && !is_emit);
  assign wr_addr = clearing ? clr_addr : b_idx;
  assign wr_data = clearing ? '0 : new_sum;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sums[wr_addr] <= wr_data;
    end
    if (q_pop) begin
      mem_q <= sums[q_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_idx    <= q_idx;
      b_item   <= q_item;
      fwd_data <= wr_data;
    end
    if (b_done && is_emit) begin
      m_tdata <= shifted[15:0];
      m_tlast <= b_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      b_valid  <= 1'b0;
      fwd_hit  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_addr == IDX_W'(POINTS - 1)) begin
          clearing <= 1'b0;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end
      if (q_pop) begin
        b_valid <= 1'b1;
        fwd_hit <= wr_en && (wr_addr == q_idx);
      end else if (b_done) begin
        b_valid <= 1'b0;
      end
      if (b_done && is_emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/frame_accumulate_average.sv
// Channel   Direction  Signals                              Contents
// s_*       in         s_tvalid s_tready s_tdata s_tlast    sample, frame_end
// m_*       out        m_tvalid m_tready m_tdata m_tlast    average, average_last
// apb       in/out     psel penable pwrite paddr pwdata ... acc_max @0, acc_shift @4
//
// One sample is taken per cycle while s_tready is high; an average passes
// through the queue, the registered accumulator read and the output register.
// After reset the block sweeps the store to zero, one entry per cycle, over
// all POINTS entries (2048 by default); s_tready stays low during that sweep.
// A stalled output holds the back end, and a four-entry queue lets the front
// keep accepting until it fills.
module frame_accumulate_average #(
  parameter int POINTS = 2048
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  input  logic        s_tlast,
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] average
  output logic        m_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W  = $clog2(POINTS);
  localparam int ITEM_W = $bits(faa_pkg::item_t);
  localparam int Q_W    = IDX_W + ITEM_W;

  // Configuration registers; the user changes them only while the block is idle (unenforced).
  logic [faa_pkg::FRAME_W-1:0] acc_max;
  logic [faa_pkg::SHIFT_W-1:0] acc_shift;
  logic                        cfg_write;

  logic                        busy;
  logic                        q_full;
  logic                        q_push;
  logic [IDX_W-1:0]            f_idx;
  faa_pkg::item_t              f_item;
  logic                        q_pop;
  logic                        q_valid;
  logic [Q_W-1:0]              q_head;
  logic [IDX_W-1:0]            h_idx;
  faa_pkg::item_t              h_item;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_max   <= faa_pkg::FRAME_W'(16);
      acc_shift <= faa_pkg::SHIFT_W'(4);
    end else if (cfg_write) begin
      case (paddr[2])
        faa_pkg::REG_ACC_MAX:   acc_max   <= pwdata[faa_pkg::FRAME_W-1:0];
        faa_pkg::REG_ACC_SHIFT: acc_shift <= pwdata[faa_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      faa_pkg::REG_ACC_MAX:   prdata = {{(32 - faa_pkg::FRAME_W){1'b0}}, acc_max};
      faa_pkg::REG_ACC_SHIFT: prdata = {{(32 - faa_pkg::SHIFT_W){1'b0}}, acc_shift};
      default:                prdata = '0;
    endcase
  end

  // Front end: tracks the point index and frame count, and tags each sample
  // with the operation it needs (overwrite, add or emit).
  faa_front #(
    .POINTS (POINTS),
    .IDX_W  (IDX_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .acc_max  (acc_max),
    .busy     (busy),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_idx    (f_idx),
    .q_item   (f_item)
  );

  faa_queue #(
    .WIDTH (Q_W),
    .DEPTH (faa_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_idx, f_item}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  assign h_idx  = q_head[Q_W-1:ITEM_W];
  assign h_item = q_head[ITEM_W-1:0];

  // Back end: the accumulator memory, its read-modify-write stage and the
  // output register.
  faa_back #(
    .POINTS (POINTS),
    .IDX_W  (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .acc_shift (acc_shift),
    .busy      (busy),
    .q_valid   (q_valid),
    .q_idx     (h_idx),
    .q_item    (h_item),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

FILE: tb/frame_accumulate_average_tb.sv
module frame_accumulate_average_tb;

  // The store depth the testbench builds the block with and predicts against.
  localparam int STORE_POINTS = 2048;
  // Cycles allowed after the last expected average before the block counts as
  // idle. An accumulating sample makes no output transaction, so it can still
  // sit in the read-modify-write pipeline or the small front queue when the
  // last average has already left.
  localparam int DRAIN_CYCLES = 16;
  // Random stimulus size and the number of averages the random part should see.
  localparam int RANDOM_SAMPLES  = 100;
  localparam int RANDOM_AVERAGES = 48;
  // Hard stop for a hung run, in time units. This covers the clearing sweep
  // after reset plus every sample at its slowest pace many times over.
  localparam int RUN_LIMIT = 3_000_000;

  // Pacing modes for the two stream sides.
  typedef enum int {
    PACE_FULL_RATE,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_mode_t;

  // One averaged point as the block should emit it.
  typedef struct {
    logic [15:0] average;
    logic        last;
  } avg_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [15:0] sample
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [15:0] average
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  frame_accumulate_average #(
    .POINTS(STORE_POINTS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted state of the block: the per-point sums, the position inside the
  // current frame, the number of frames summed so far and the mode that was
  // fixed at the first point of the current frame.
  logic [31:0] point_sum_store [STORE_POINTS];
  int unsigned point_pos;
  logic [15:0] frames_done;
  bit          frame_emits;
  bit          frame_in_progress;
  logic [15:0] acc_max_cfg;
  logic [4:0]  acc_shift_cfg;

  // Averages predicted but not yet seen on the output stream, oldest first.
  avg_result_t averages_due[$];

  int errors;
  int samples_sent;
  int averages_seen;
  int send_idle_pct;
  int recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a run that never drains is a failure.
  initial begin
    #RUN_LIMIT;
    $display("Some tests failed");
    $finish;
  end

  // The receiver decides at every falling edge whether it takes a transaction
  // in the next cycle, so stalls land on every phase of the output pipeline.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output checker. Each accepted average is compared with the oldest
  // prediction; anything arriving with nothing predicted is an error too.
  always @(posedge clk) begin : check_averages
    avg_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (averages_due.size() == 0) begin
        $error("unexpected average transaction: average %h last %b", m_tdata, m_tlast);
        errors++;
      end else begin
        want = averages_due.pop_front();
        if (m_tdata !== want.average) begin
          $error("average: expected %h, got %h", want.average, m_tdata);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("average_last: expected %b, got %b", want.last, m_tlast);
          errors++;
        end
        averages_seen++;
      end
    end
  end

  // Advance the predicted state by one accepted sample. The mode of a frame
  // is decided at its first point and holds until its last point, even when
  // acc_max changes in between. The first frame of a run overwrites its
  // entries, later frames add with wrap at 32 bits.
  task automatic predict_sample(input logic [15:0] smp, input logic lst);
    logic [31:0] widened;
    logic [31:0] shifted;
    widened = {{16{smp[15]}}, smp};
    if (!frame_in_progress) begin
      frame_emits = (frames_done >= acc_max_cfg);
      frame_in_progress = 1'b1;
    end
    if (frame_emits) begin
      shifted = $signed(point_sum_store[point_pos]) >>> acc_shift_cfg;
      averages_due.push_back('{average: shifted[15:0], last: lst});
    end else if (frames_done == 16'd0) begin
      point_sum_store[point_pos] = widened;
    end else begin
      point_sum_store[point_pos] = point_sum_store[point_pos] + widened;
    end
    if (lst) begin
      point_pos = 0;
      frame_in_progress = 1'b0;
      frames_done = frame_emits ? 16'd0 : frames_done + 16'd1;
    end else begin
      // A frame longer than the store wraps back onto its first entries.
      point_pos = (point_pos + 1) % STORE_POINTS;
    end
  endtask

  // Send one sample transaction, with random gaps before it. Every call starts
  // and ends at a falling edge; tvalid stays high from one sample to the next
  // unless a gap drops it.
  task automatic send_sample(input logic [15:0] smp, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_sample(smp, lst);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [15:0] pts[$]);
    foreach (pts[k]) send_sample(pts[k], k == pts.size() - 1);
  endtask

  // Hold the input stream until every predicted average has left, then give
  // the pipeline time to finish any accumulating samples.
  task automatic settle_block();
    s_tvalid <= 1'b0;
    while (averages_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One write over the configuration port: setup cycle, then access cycle.
  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (reg_sel == faa_pkg::REG_ACC_MAX) begin
      acc_max_cfg = value[15:0];
    end else begin
      acc_shift_cfg = value[4:0];
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Read a register back and compare it with the value last written.
  task automatic check_reg(input logic reg_sel, input logic [31:0] want, input string name);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_sel, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $error("%s: expected %h, got %h", name, want, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Reprogram both registers while the block is idle and read them back.
  task automatic configure(input logic [15:0] frames, input logic [4:0] shift);
    settle_block();
    write_reg(faa_pkg::REG_ACC_MAX, {16'd0, frames});
    write_reg(faa_pkg::REG_ACC_SHIFT, {27'd0, shift});
    check_reg(faa_pkg::REG_ACC_MAX, {16'd0, acc_max_cfg}, "acc_max");
    check_reg(faa_pkg::REG_ACC_SHIFT, {27'd0, acc_shift_cfg}, "acc_shift");
  endtask

  task automatic set_pace(input pace_mode_t mode);
    case (mode)
      PACE_FULL_RATE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      PACE_SENDER_IDLE: begin
        send_idle_pct = 58;
        recv_stall_pct = 0;
      end
      PACE_RECEIVER_STALL: begin
        send_idle_pct = 0;
        recv_stall_pct = 58;
      end
      default: begin
        send_idle_pct = 34;
        recv_stall_pct = 34;
      end
    endcase
  endtask

  // Samples lean toward the extremes so that sums and shifts hit their edges.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // The registers come out of reset at 16 and 4. With acc_max at zero every
  // frame emits, and right after reset the cleared store reads as zeros.
  task automatic test_reset_and_zero_frames();
    set_pace(PACE_FULL_RATE);
    check_reg(faa_pkg::REG_ACC_MAX, {16'd0, acc_max_cfg}, "acc_max");
    check_reg(faa_pkg::REG_ACC_SHIFT, {27'd0, acc_shift_cfg}, "acc_shift");
    configure(16'd0, 5'd0);
    send_frame('{16'h7FFF, 16'h8000, 16'h1234});
    settle_block();
  endtask

  // First frame overwrites, the second adds, the third emits. The averages are
  // checked at a mid shift, at no shift (sums truncated to 16 bits) and at the
  // largest shift (only the sign survives).
  task automatic test_sum_and_shift();
    set_pace(PACE_BOTH);
    configure(16'd2, 5'd1);
    repeat (2) send_frame('{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF});
    send_frame('{16'h0000, 16'h5555, 16'hAAAA, 16'h0F0F});
    configure(16'd2, 5'd0);
    repeat (2) send_frame('{16'h7FFF, 16'h8000});
    send_frame('{16'h0000, 16'h0000});
    configure(16'd1, 5'd31);
    send_frame('{16'h7FFF, 16'h8000});
    send_frame('{16'hFFFF, 16'h0000});
    settle_block();
  endtask

  // A register change in the middle of a frame must not switch that frame's
  // mode: the emitting frame keeps emitting after acc_max is raised, and only
  // the next frame starts a new run of sums.
  task automatic test_write_inside_frame();
    set_pace(PACE_RECEIVER_STALL);
    configure(16'd1, 5'd2);
    send_frame('{16'h0100, 16'hFF00, 16'h7FFF});
    send_sample(16'h1111, 1'b0);
    configure(16'd5, 5'd0);
    send_sample(16'h2222, 1'b0);
    send_sample(16'h3333, 1'b1);
    send_frame('{16'h4444, 16'h8001});
    settle_block();
  endtask

  // A frame longer than the store wraps its point index back to zero, so the
  // last samples of the frame land on the first entries again.
  task automatic test_frame_past_store();
    logic [15:0] pts[$];
    set_pace(PACE_BOTH);
    configure(16'd1, 5'd0);
    repeat (STORE_POINTS + 2) pts.push_back(pick_sample());
    send_frame(pts);
    send_frame('{16'h0000, 16'h0000, 16'h0000});
    settle_block();
  endtask

  // Random frames over many register settings and all pacing modes. Frames
  // are mostly short so that averages come often; a few are longer.
  task automatic test_random_frames();
    int first_sample;
    int first_average;
    int phase;
    int frame_count;
    int frame_len;
    logic [15:0] frames;
    logic [4:0]  shift;
    first_sample = samples_sent;
    first_average = averages_seen;
    phase = 0;
    while (samples_sent - first_sample < RANDOM_SAMPLES ||
           averages_seen - first_average < RANDOM_AVERAGES) begin
      case ($urandom_range(9))
        0: frames = 16'd0;
        1: frames = 16'hFFFF;
        2: frames = 16'($urandom_range(4, 40));
        default: frames = 16'($urandom_range(1, 3));
      endcase
      case ($urandom_range(5))
        0: shift = 5'd0;
        1: shift = 5'd31;
        default: shift = 5'($urandom_range(0, 8));
      endcase
      configure(frames, shift);
      set_pace(pace_mode_t'(phase % 4));
      frame_count = $urandom_range(4, 12);
      repeat (frame_count) begin
        frame_len = ($urandom_range(9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 6);
        for (int k = 0; k < frame_len; k++) send_sample(pick_sample(), k == frame_len - 1);
        // Now and then the sender waits for the output side to empty.
        if ($urandom_range(15) == 0) settle_block();
      end
      phase++;
    end
    settle_block();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    samples_sent = 0;
    averages_seen = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (point_sum_store[k]) point_sum_store[k] = '0;
    point_pos = 0;
    frames_done = '0;
    frame_emits = 1'b0;
    frame_in_progress = 1'b0;
    acc_max_cfg = 16'd16;
    acc_shift_cfg = 5'd4;

    // Synchronous reset, released at a falling edge. The block then clears
    // its store before it raises s_tready.
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_and_zero_frames();
    test_sum_and_shift();
    test_write_inside_frame();
    test_frame_past_store();
    test_random_frames();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/faa_pkg.sv
rtl/faa_front.sv
rtl/faa_queue.sv
rtl/faa_back.sv
rtl/frame_accumulate_average.sv
tb/frame_accumulate_average_tb.sv
